// File: rtl/iptc_record_stream_measurer_assert.svh
// Assertion macros shared by the record stream measurer RTL.
`ifndef IPTC_RECORD_STREAM_MEASURER_ASSERT_SVH
`define IPTC_RECORD_STREAM_MEASURER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside reset.
`define IPTC_ASSERT(name, ck, rn, prop, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define IPTC_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IPTC_ASSERT(name, ck, rn, prop, msg)
`define IPTC_ASSERT_NEXT(name, ck, rn, ante, cons, msg)

`endif

`endif

// File: rtl/iptc_pkg.sv
// Shared types and constants of the record stream measurer.
`default_nettype none

package iptc_pkg;

  // Width of the saturating byte counters.
  localparam int unsigned COUNT_WIDTH = 32;
  // Width of the declared record length and of the result fields.
  localparam int unsigned DECL_WIDTH  = 32;
  localparam int unsigned FIELD_WIDTH = 32;
  localparam int unsigned SUM_WIDTH   = DECL_WIDTH + 1;

  localparam logic [7:0] MARKER_BYTE = 8'h1C;
  localparam logic [7:0] LONG_FLAG   = 8'h80;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [DECL_WIDTH-1:0]  decl_t;
  typedef logic [SUM_WIDTH-1:0]   sum_t;

  localparam count_t COUNT_MAX   = '1;
  localparam sum_t   COUNT_LIMIT = (SUM_WIDTH'(1) << COUNT_WIDTH) - SUM_WIDTH'(1);

  // Index of the last of the four long-length bytes.
  localparam logic [1:0] EXT_LAST = 2'd3;

  typedef enum logic [8:0] {
    PH_SEEK = 9'b000000001,
    PH_MARK = 9'b000000010,
    PH_DSET = 9'b000000100,
    PH_REC  = 9'b000001000,
    PH_LEN0 = 9'b000010000,
    PH_EXT  = 9'b000100000,
    PH_LEN1 = 9'b001000000,
    PH_DATA = 9'b010000000,
    PH_DONE = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic                   marker_found;
    logic [FIELD_WIDTH-1:0] start_offset;
    logic [FIELD_WIDTH-1:0] stream_length;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/iptc_parser.sv
// Record parser: phase tracking, saturating counters and result forming.
`default_nettype none
`include "iptc_record_stream_measurer_assert.svh"

module iptc_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   push,
  output iptc_pkg::result_t      res
);

  iptc_pkg::phase_t phase_r, phase_nxt;
  iptc_pkg::count_t pos_r, pos_nxt;
  iptc_pkg::count_t first_r, first_nxt;
  iptc_pkg::count_t counted_r, counted_nxt;
  iptc_pkg::decl_t  decl_r, decl_nxt;
  iptc_pkg::decl_t  left_r, left_nxt;
  logic [1:0]       ext_r, ext_nxt;
  logic             seen_r, seen_nxt;

  logic             count_one;
  logic             add_data;
  logic             len_done;
  iptc_pkg::decl_t  addend;
  iptc_pkg::sum_t   sum;
  iptc_pkg::decl_t  left_dec;

  // Decode the phase for the incoming word
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    decl_nxt  = decl_r;
    left_nxt  = left_r;
    ext_nxt   = ext_r;
    seen_nxt  = seen_r;
    count_one = 1'b0;
    add_data  = 1'b0;
    len_done  = 1'b0;
    left_dec  = (left_r != '0) ? left_r - iptc_pkg::DECL_WIDTH'(1) : left_r;
    case (phase_r)
      iptc_pkg::PH_SEEK: begin
        if (data_byte == iptc_pkg::MARKER_BYTE) begin
          seen_nxt  = 1'b1;
          first_nxt = pos_r;
          count_one = 1'b1;
          phase_nxt = iptc_pkg::PH_DSET;
        end
      end
      iptc_pkg::PH_MARK: begin
        if (data_byte == iptc_pkg::MARKER_BYTE) begin
          count_one = 1'b1;
          phase_nxt = iptc_pkg::PH_DSET;
        end else begin
          phase_nxt = iptc_pkg::PH_DONE;
        end
      end
      iptc_pkg::PH_DSET: begin
        count_one = 1'b1;
        phase_nxt = iptc_pkg::PH_REC;
      end
      iptc_pkg::PH_REC: begin
        count_one = 1'b1;
        phase_nxt = iptc_pkg::PH_LEN0;
      end
      iptc_pkg::PH_LEN0: begin
        count_one = 1'b1;
        if ((data_byte & iptc_pkg::LONG_FLAG) != 8'h00) begin
          decl_nxt  = '0;
          ext_nxt   = '0;
          phase_nxt = iptc_pkg::PH_EXT;
        end else begin
          decl_nxt  = iptc_pkg::DECL_WIDTH'({data_byte, 8'h00});
          phase_nxt = iptc_pkg::PH_LEN1;
        end
      end
      iptc_pkg::PH_EXT: begin
        count_one = 1'b1;
        decl_nxt  = {decl_r[iptc_pkg::DECL_WIDTH-9:0], data_byte};
        if (ext_r == iptc_pkg::EXT_LAST) begin
          ext_nxt  = '0;
          len_done = 1'b1;
        end else begin
          ext_nxt = ext_r + 2'd1;
        end
      end
      iptc_pkg::PH_LEN1: begin
        count_one = 1'b1;
        decl_nxt  = decl_r | iptc_pkg::DECL_WIDTH'(data_byte);
        len_done  = 1'b1;
      end
      iptc_pkg::PH_DATA: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          add_data  = 1'b1;
          phase_nxt = iptc_pkg::PH_MARK;
        end
      end
      default: begin
        phase_nxt = iptc_pkg::PH_DONE;
      end
    endcase

    // Enter the data or go straight to the next marker
    if (len_done) begin
      if (decl_nxt == '0) begin
        phase_nxt = iptc_pkg::PH_MARK;
      end else begin
        left_nxt  = decl_nxt;
        phase_nxt = iptc_pkg::PH_DATA;
      end
    end
  end

  // Add one header byte or a whole record's data, saturating
  always_comb begin
    addend = add_data ? decl_r : iptc_pkg::DECL_WIDTH'(1);
    sum    = iptc_pkg::SUM_WIDTH'(counted_r) + iptc_pkg::SUM_WIDTH'(addend);
    if (!(count_one || add_data)) begin
      counted_nxt = counted_r;
    end else if (sum > iptc_pkg::COUNT_LIMIT) begin
      counted_nxt = iptc_pkg::COUNT_MAX;
    end else begin
      counted_nxt = iptc_pkg::COUNT_WIDTH'(sum);
    end
    pos_nxt = (pos_r == iptc_pkg::COUNT_MAX) ? pos_r : pos_r + iptc_pkg::COUNT_WIDTH'(1);
  end

  // Form the result from the state after this word
  always_comb begin
    push              = acc && last_byte;
    res.marker_found  = seen_nxt;
    res.start_offset  = seen_nxt ? iptc_pkg::FIELD_WIDTH'(first_nxt) : '0;
    res.stream_length = seen_nxt ? iptc_pkg::FIELD_WIDTH'(counted_nxt) : '0;
  end

  // Advance on each accepted word, clear after the last one
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      phase_r   <= iptc_pkg::PH_SEEK;
      pos_r     <= '0;
      first_r   <= '0;
      counted_r <= '0;
      decl_r    <= '0;
      left_r    <= '0;
      ext_r     <= '0;
      seen_r    <= 1'b0;
    end else if (acc) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      first_r   <= first_nxt;
      counted_r <= counted_nxt;
      decl_r    <= decl_nxt;
      left_r    <= left_nxt;
      ext_r     <= ext_nxt;
      seen_r    <= seen_nxt;
    end
  end

  `IPTC_ASSERT(a_seek_unseen, clk, rst_n, phase_r != iptc_pkg::PH_SEEK || !seen_r, "marker flagged while still seeking")
  `IPTC_ASSERT(a_data_left, clk, rst_n, phase_r != iptc_pkg::PH_DATA || left_r != '0, "data phase with nothing left")
  `IPTC_ASSERT_NEXT(a_last_clears, clk, rst_n, push, phase_r == iptc_pkg::PH_SEEK && counted_r == '0 && pos_r == '0, "state not cleared after last word")

endmodule

`default_nettype wire

// File: rtl/iptc_out_buf.sv
// Result register with a skid stage so the input side keeps flowing.
`default_nettype none
`include "iptc_record_stream_measurer_assert.svh"

module iptc_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire iptc_pkg::result_t push_res,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output iptc_pkg::result_t      out_res
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  iptc_pkg::result_t main_res_r;
  iptc_pkg::result_t skid_res_r;
  logic              pop;

  assign pop = main_valid_r && !out_stall;

  // Track occupancy of the two stages
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (pop) begin
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_valid_nxt = 1'b1;
      end else begin
        main_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Load the payload registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_res_r <= skid_res_r;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_res_r <= push_res;
      end else begin
        main_res_r <= push_res;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_res_r;

  `IPTC_ASSERT(a_skid_behind_main, clk, rst_n, !skid_valid_r || main_valid_r, "skid holds a word while output is empty")
  `IPTC_ASSERT_NEXT(a_skid_fill, clk, rst_n, push && main_valid_r && out_stall && !skid_valid_r, skid_valid_r && main_valid_r, "stalled result lost on push")
  `IPTC_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_valid_r && !out_stall, !skid_valid_r && main_valid_r, "skid word not moved forward")

endmodule

`default_nettype wire

// File: rtl/iptc_record_stream_measurer.sv
// Top level of the IPTC record stream measurer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   in_     | input     | in_valid / in_stall   | data_byte, last_byte
//   out_    | output    | out_valid / out_stall | marker_found, start_offset,
//           |           |                       | stream_length
//
// One byte is accepted per cycle while in_stall is low; the parser state updates at the accepting edge.
// A result is registered at the edge that accepts its last byte, on out_ or behind a stalled result.
// Results sit in an output register backed by a skid stage; in_stall rises only
// when both are full, i.e. two results wait behind a stalled output.
// Synchronous active-low reset clears the parser and empties both stages.
`default_nettype none

module iptc_record_stream_measurer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_marker_found,
  output logic [31:0]      out_start_offset,
  output logic [31:0]      out_stream_length
);

  logic              acc;
  logic              push;
  logic              full;
  iptc_pkg::result_t push_res;
  iptc_pkg::result_t out_res;

  // Take a word whenever the skid stage is free
  assign in_stall = full;
  assign acc      = in_valid && !full;

  iptc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .push      (push),
    .res       (push_res)
  );

  iptc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_marker_found  = out_res.marker_found;
  assign out_start_offset  = out_res.start_offset;
  assign out_stream_length = out_res.stream_length;

endmodule

`default_nettype wire

// File: sim/iptc_report_check_pkg.sv
// Scoreboard that predicts the per-buffer reports of the record stream measurer.
`timescale 1ns / 1ps

package iptc_report_check_pkg;
  import iptc_pkg::*;

  class record_length_tracker;
    // Parser state mirrored from the block
    phase_t      phase;
    count_t      position;
    count_t      first_offset;
    count_t      counted;
    decl_t       declared;
    decl_t       remaining;
    logic [1:0]  ext_idx;
    logic        marker_seen;

    // Reports still owed by the block, oldest first
    result_t     awaited[$];

    int unsigned faults;
    int unsigned parsed_bytes;
    int unsigned buffers;
    int unsigned found_buffers;
    int unsigned reports_matched;

    function new();
      faults          = 0;
      parsed_bytes    = 0;
      buffers         = 0;
      found_buffers   = 0;
      reports_matched = 0;
      restart();
    endfunction

    // Return to the state of a fresh buffer.
    function void restart();
      phase        = PH_SEEK;
      position     = '0;
      first_offset = '0;
      counted      = '0;
      declared     = '0;
      remaining    = '0;
      ext_idx      = '0;
      marker_seen  = 1'b0;
    endfunction

    // Add onto a byte counter, holding at the counter's top value.
    function count_t sat_sum(count_t a, decl_t b);
      sum_t s;
      s = sum_t'(a) + sum_t'(b);
      return (s > COUNT_LIMIT) ? COUNT_MAX : count_t'(s);
    endfunction

    // Enter the data of a record, or go straight back to a marker when it is empty.
    function void after_length();
      if (declared == '0) begin
        phase = PH_MARK;
      end else begin
        remaining = declared;
        phase     = PH_DATA;
      end
    endfunction

    // Note one accepted input word and queue the report it closes, if any.
    function void take_byte(logic [7:0] b, logic last);
      result_t r;
      if (phase != PH_DONE && (phase != PH_SEEK || b == MARKER_BYTE)) parsed_bytes++;
      case (phase)
        PH_SEEK: begin
          if (b == MARKER_BYTE) begin
            marker_seen  = 1'b1;
            first_offset = position;
            counted      = sat_sum(counted, decl_t'(1));
            phase        = PH_DSET;
          end
        end
        PH_MARK: begin
          if (b == MARKER_BYTE) begin
            counted = sat_sum(counted, decl_t'(1));
            phase   = PH_DSET;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_DSET: begin
          counted = sat_sum(counted, decl_t'(1));
          phase   = PH_REC;
        end
        PH_REC: begin
          counted = sat_sum(counted, decl_t'(1));
          phase   = PH_LEN0;
        end
        PH_LEN0: begin
          counted = sat_sum(counted, decl_t'(1));
          if ((b & LONG_FLAG) != '0) begin
            declared = '0;
            ext_idx  = '0;
            phase    = PH_EXT;
          end else begin
            declared = decl_t'(b) << 8;
            phase    = PH_LEN1;
          end
        end
        PH_EXT: begin
          counted  = sat_sum(counted, decl_t'(1));
          declared = {declared[DECL_WIDTH-9:0], b};
          if (ext_idx == EXT_LAST) begin
            ext_idx = '0;
            after_length();
          end else begin
            ext_idx = ext_idx + 2'd1;
          end
        end
        PH_LEN1: begin
          counted  = sat_sum(counted, decl_t'(1));
          declared = declared | decl_t'(b);
          after_length();
        end
        PH_DATA: begin
          if (remaining != '0) remaining = remaining - decl_t'(1);
          // whole record data is credited only once its final word is in
          if (remaining == '0) begin
            counted = sat_sum(counted, declared);
            phase   = PH_MARK;
          end
        end
        default: phase = PH_DONE;
      endcase
      position = sat_sum(position, decl_t'(1));

      if (last) begin
        r.marker_found  = marker_seen;
        r.start_offset  = marker_seen ? first_offset : '0;
        r.stream_length = marker_seen ? counted : '0;
        awaited.push_back(r);
        buffers++;
        if (marker_seen) found_buffers++;
        restart();
      end
    endfunction

    // Count a failure; only the first ten are shown.
    function void log_fault(string what);
      if (faults < 10) $display("mismatch: %s", what);
      faults++;
    endfunction

    // Compare a report word from the block with the oldest one owed.
    function void match_report(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        log_fault($sformatf("report with none owed: found=%0b start=%0d length=%0d",
                            got.marker_found, got.start_offset, got.stream_length));
        return;
      end
      want = awaited.pop_front();
      if (got.marker_found !== want.marker_found ||
          got.start_offset !== want.start_offset ||
          got.stream_length !== want.stream_length) begin
        log_fault($sformatf({"expected found=%0b start=%0d length=%0d, ",
                             "got found=%0b start=%0d length=%0d"},
                            want.marker_found, want.start_offset, want.stream_length,
                            got.marker_found, got.start_offset, got.stream_length));
      end else begin
        reports_matched++;
      end
    endfunction
  endclass

endpackage

// File: sim/tb_top.sv
// Top-level testbench of the record stream measurer: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_top;
  import iptc_pkg::*;
  import iptc_report_check_pkg::*;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        out_marker_found;
  logic [31:0] out_start_offset;
  logic [31:0] out_stream_length;

  // Idle mixes per phase: none, sender only, receiver only, both
  int unsigned send_gap_pct[4] = '{0, 49, 0, 11};
  int unsigned stall_mix_pct[4] = '{0, 0, 49, 11};
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned sent_words    = 0;

  record_length_tracker tracker = new();
  logic [7:0]           buffer_bytes[$];
  result_t              report_word;

  iptc_record_stream_measurer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_marker_found (out_marker_found),
    .out_start_offset (out_start_offset),
    .out_stream_length(out_stream_length)
  );

  always #5 clk = ~clk;

  // Offer one word, idling first at random, and hold it until accepted.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_last_byte <= 1'($urandom);
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_words++;
    tracker.take_byte(b, last);
  endtask

  // Send the whole buffer, flagging its final word.
  task automatic send_buffer();
    for (int i = 0; i < buffer_bytes.size(); i++)
      send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
  endtask

  // Build a buffer of well-formed records with random content, or plain noise; some end inside a record.
  task automatic build_buffer();
    int unsigned form;
    int unsigned len;
    int unsigned records;
    int unsigned tail;
    int unsigned cut;
    bit          stop;
    buffer_bytes.delete();
    stop = 1'b0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12))
        buffer_bytes.push_back(($urandom_range(5) == 0) ? MARKER_BYTE : 8'($urandom));
    end else begin
      repeat ($urandom_range(3)) buffer_bytes.push_back(8'($urandom_range(8'h1D, 8'hFF)));
      records = $urandom_range(4);
      for (int r = 0; r < records && !stop; r++) begin
        buffer_bytes.push_back(MARKER_BYTE);
        buffer_bytes.push_back(8'($urandom));
        buffer_bytes.push_back(8'($urandom));
        form = $urandom_range(9);
        len  = $urandom_range(6);
        if (form < 5) begin
          // short length, small
          buffer_bytes.push_back(8'h00);
          buffer_bytes.push_back(8'(len));
        end else if (form == 5) begin
          // short length of 256 or more: buffer ends inside the data
          buffer_bytes.push_back(8'($urandom_range(1, 8'h7F)));
          buffer_bytes.push_back(8'($urandom));
          stop = 1'b1;
        end else if (form < 8) begin
          // long length, small
          buffer_bytes.push_back(LONG_FLAG | 8'($urandom_range(8'h7F)));
          buffer_bytes.push_back(8'h00);
          buffer_bytes.push_back(8'h00);
          buffer_bytes.push_back(8'h00);
          buffer_bytes.push_back(8'(len));
        end else begin
          // long length, huge: buffer ends inside the data
          buffer_bytes.push_back(LONG_FLAG | 8'($urandom));
          buffer_bytes.push_back(8'($urandom_range(1, 8'hFF)));
          repeat (3) buffer_bytes.push_back(8'($urandom));
          stop = 1'b1;
        end
        if (stop) len = $urandom_range(8);
        repeat (len) buffer_bytes.push_back(8'($urandom));
      end
      if (!stop) begin
        tail = $urandom_range(3);
        if (tail == 1) begin
          // terminator, then words the parser must ignore
          buffer_bytes.push_back(8'($urandom_range(8'h1D, 8'hFF)));
          repeat ($urandom_range(4))
            buffer_bytes.push_back(($urandom_range(2) == 0) ? MARKER_BYTE : 8'($urandom));
        end else if (tail == 2) begin
          buffer_bytes.push_back(MARKER_BYTE);
        end
      end
    end
    if (buffer_bytes.size() == 0) buffer_bytes.push_back(8'($urandom));
    // cut short now and then, to end inside headers and data
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(1, buffer_bytes.size());
      while (buffer_bytes.size() > cut) void'(buffer_bytes.pop_back());
    end
  endtask

  // Hold the sender until every owed report has come back, within a bound.
  task automatic drain_reports();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Receiver: check each accepted report word, then choose the next stall.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        report_word.marker_found  = out_marker_found;
        report_word.start_offset  = out_start_offset;
        report_word.stream_length = out_stream_length;
        tracker.match_report(report_word);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_gap_pct[p];
      stall_pct     = stall_mix_pct[p];
      if (p == 0) begin
        // lone marker as the final word
        buffer_bytes = '{MARKER_BYTE};
        send_buffer();
        // no marker at all, data extremes
        buffer_bytes = '{8'h00, 8'hFF};
        send_buffer();
        // offset start, empty record, short record ending on its data,
        // long-form record, stop on a non-marker, ignored marker at the end
        buffer_bytes = '{8'h55, MARKER_BYTE, 8'h02, 8'h05, 8'h00, 8'h00,
                         MARKER_BYTE, 8'h02, 8'h78, 8'h00, 8'h02, 8'hAB, 8'hCD,
                         MARKER_BYTE, 8'h01, 8'h5A, LONG_FLAG, 8'h00, 8'h00, 8'h00,
                         8'h01, 8'h7E, 8'h33, MARKER_BYTE};
        send_buffer();
      end
      while (sent_words < (p + 1) * 437) begin
        build_buffer();
        send_buffer();
      end
      drain_reports();
    end

    // Let any stray report surface before the verdict
    repeat (20) @(posedge clk);
    if (tracker.awaited.size() != 0)
      tracker.log_fault($sformatf("%0d reports never arrived", tracker.awaited.size()));

    $display("Covered %0d buffers (%0d with a marker), %0d words sent, %0d parsed",
             tracker.buffers, tracker.found_buffers, sent_words, tracker.parsed_bytes);
    $display("Reports matched over four idle mixes: %0d, faults: %0d",
             tracker.reports_matched, tracker.faults);
    if (tracker.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: iptc_record_stream_measurer.f
+incdir+rtl
rtl/iptc_pkg.sv
rtl/iptc_parser.sv
rtl/iptc_out_buf.sv
rtl/iptc_record_stream_measurer.sv
sim/iptc_report_check_pkg.sv
sim/tb_top.sv
